// ----- rtl/core/cvep_pkg.sv -----
`default_nettype none

package cvep_pkg;

   // frame geometry limits
   localparam int MaxWidth   = 512;
   localparam int MaxHeight  = 256;
   localparam int MaxShift   = 4;
   localparam int ColW       = $clog2(MaxWidth);
   localparam int EmitW      = ColW + 1;
   localparam int RowW       = $clog2(MaxHeight);
   localparam int StoreDepth = MaxWidth * MaxHeight;
   localparam int StoreAw    = $clog2(StoreDepth);
   localparam int BurstMax   = MaxShift + 2;
   localparam int BurstW     = $clog2(BurstMax + 1);
   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_PERSISTENCE = 3'd0,
      CSR_SCANLINE    = 3'd1,
      CSR_CHROMA      = 3'd2,
      CSR_BLEED       = 3'd3,
      CSR_WIDTH       = 3'd4,
      CSR_HEIGHT      = 3'd5
   } cvep_csr_type;

   typedef struct packed {
      logic [7:0]  persistence_weight;
      logic [7:0]  scanline_strength;
      logic [2:0]  chroma_offset;
      logic [7:0]  bleed_weight;
      logic [9:0]  frame_width;
      logic [8:0]  frame_height;
   } cvep_cfg_type;

   typedef struct packed {
      logic [7:0]  pixel_red;
      logic [7:0]  pixel_green;
      logic [7:0]  pixel_blue;
      logic [31:0] frame_number;
   } cvep_req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       run_last;
      logic       frame_end;
   } cvep_rsp_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } cvep_rgb_type;

   // one classified pixel handed from front to back
   typedef struct packed {
      cvep_rgb_type        pixel;
      logic [ColW-1:0]     column;
      logic                row_end;
      logic                frame_last;
      logic                shift_neg;
   } cvep_job_type;

   typedef enum logic [2:0] {
      F_CLEAR,
      F_IDLE,
      F_BLEND,
      F_SCALE,
      F_PUSH
   } cvep_front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_CHECK,
      B_FETCH_CUR,
      B_FETCH_RT,
      B_MIX,
      B_EMIT
   } cvep_back_state_type;

   // floor(x / 255) for x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return t[15:8];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cvep_front.sv -----
`default_nettype none

module cvep_front (
   input  logic                  clock,
   input  logic                  reset,
   input  cvep_pkg::cvep_cfg_type cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cvep_pkg::cvep_req_type req_data,
   output logic                  push_valid,
   input  logic                  push_ready,
   output cvep_pkg::cvep_job_type push_job
);
   import cvep_pkg::*;

   localparam int IdxW = RowW + 10 + 1;

   cvep_front_state_type state_ff, state_in;

   logic [StoreAw-1:0] clr_addr_ff;
   logic [ColW-1:0]    col_ff, col_in;
   logic [RowW-1:0]    row_ff, row_in;
   logic [StoreAw-1:0] idx_ff;
   cvep_rgb_type       cur_ff, blend_ff, blend_in, store_rd_ff;
   logic [15:0]        prod_r_ff, prod_g_ff, prod_b_ff;
   logic               even_ff, row_end_ff, frame_last_ff;
   logic [ColW-1:0]    colj_ff;
   logic [13:0]        mod_ff, mod_in;

   logic [23:0]        store_mem [StoreDepth];

   logic [9:0]         w_cl;
   logic [8:0]         h_cl;
   logic               row_end, frame_last, accept;
   logic [IdxW-1:0]    idx_full;
   logic [StoreAw-1:0] idx_now;
   logic [RowW:0]      row_inc;
   logic [9:0]         sum3;
   logic [16:0]        q_prod;
   logic [3:0]         q_est;
   logic [8:0]         rem0, rem1;
   logic [7:0]         scale;
   cvep_rgb_type       scaled;

   // clamp the frame size
   always_comb begin
      if (cfg.frame_width < 10'd3) begin
         w_cl = 10'd3;
      end else if (cfg.frame_width > 10'(MaxWidth)) begin
         w_cl = 10'(MaxWidth);
      end else begin
         w_cl = cfg.frame_width;
      end
      if (cfg.frame_height < 9'd1) begin
         h_cl = 9'd1;
      end else if (cfg.frame_height > 9'(MaxHeight)) begin
         h_cl = 9'(MaxHeight);
      end else begin
         h_cl = cfg.frame_height;
      end
   end

   // position of the arriving pixel
   always_comb begin
      accept     = req_valid && !req_stall;
      row_end    = {1'b0, col_ff} >= (w_cl - 10'd1);
      frame_last = row_end && ({1'b0, row_ff} >= (h_cl - 9'd1));
      idx_full   = IdxW'(row_ff * w_cl) + IdxW'(col_ff);
      idx_now    = idx_full[StoreAw-1:0];
      row_inc    = {1'b0, row_ff} + (RowW+1)'(1);
      col_in     = col_ff;
      row_in     = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = ((RowW+2)'(row_inc) >= (RowW+2)'(h_cl)) ? '0 : row_inc[RowW-1:0];
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   // frame number mod 30, folded one byte at a time (256 = 16 mod 30)
   always_comb begin
      sum3 = {2'd0, req_data.frame_number[15:8]} + {2'd0, req_data.frame_number[23:16]}
           + {2'd0, req_data.frame_number[31:24]};
      case (state_ff)
         F_IDLE:  mod_in = {6'd0, req_data.frame_number[7:0]} + {sum3, 4'd0};
         F_BLEND: mod_in = {6'd0, mod_ff[7:0]} + {4'd0, mod_ff[13:8], 4'd0};
         F_SCALE: mod_in = {6'd0, mod_ff[7:0]} + {7'd0, mod_ff[10:8], 4'd0};
         default: mod_in = mod_ff;
      endcase
      q_prod = 17'(mod_ff[8:0] * 9'd273);
      q_est  = q_prod[16:13];
      rem0   = mod_ff[8:0] - 9'(q_est * 5'd30);
      rem1   = (rem0 >= 9'd30) ? rem0 - 9'd30 : rem0;
   end

   // persistence blend with the stored frame, then scanline darkening
   always_comb begin
      if (cfg.persistence_weight >= 8'd3) begin
         blend_in.r = 8'((17'(store_rd_ff.r * cfg.persistence_weight)
                    + 17'(cur_ff.r * (9'd256 - {1'b0, cfg.persistence_weight}))) >> 8);
         blend_in.g = 8'((17'(store_rd_ff.g * cfg.persistence_weight)
                    + 17'(cur_ff.g * (9'd256 - {1'b0, cfg.persistence_weight}))) >> 8);
         blend_in.b = 8'((17'(store_rd_ff.b * cfg.persistence_weight)
                    + 17'(cur_ff.b * (9'd256 - {1'b0, cfg.persistence_weight}))) >> 8);
      end else begin
         blend_in = cur_ff;
      end
      scale = 8'd255 - cfg.scanline_strength;
      if (cfg.scanline_strength != 8'd0 && even_ff) begin
         scaled.r = div255(prod_r_ff);
         scaled.g = div255(prod_g_ff);
         scaled.b = div255(prod_b_ff);
      end else begin
         scaled = blend_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_CLEAR: begin
            if (clr_addr_ff == StoreAw'(StoreDepth - 1)) state_in = F_IDLE;
         end
         F_IDLE: begin
            if (req_valid) state_in = F_BLEND;
         end
         F_BLEND: state_in = F_SCALE;
         F_SCALE: state_in = F_PUSH;
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_stall              = (state_ff != F_IDLE);
      push_valid             = (state_ff == F_PUSH);
      push_job.pixel         = scaled;
      push_job.column        = colj_ff;
      push_job.row_end       = row_end_ff;
      push_job.frame_last    = frame_last_ff;
      push_job.shift_neg     = (rem1 >= 9'd15);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_CLEAR;
         clr_addr_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_ff + StoreAw'(1);
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mod_ff <= mod_in;
      if (accept) begin
         cur_ff.r      <= req_data.pixel_red;
         cur_ff.g      <= req_data.pixel_green;
         cur_ff.b      <= req_data.pixel_blue;
         idx_ff        <= idx_now;
         even_ff       <= !row_ff[0];
         row_end_ff    <= row_end;
         frame_last_ff <= frame_last;
         colj_ff       <= col_ff;
      end
      if (state_ff == F_BLEND) blend_ff <= blend_in;
      if (state_ff == F_SCALE) begin
         prod_r_ff <= 16'(blend_ff.r * scale);
         prod_g_ff <= 16'(blend_ff.g * scale);
         prod_b_ff <= 16'(blend_ff.b * scale);
      end
   end

   // previous-frame store: zeroed by the clearing pass after reset
   always_ff @(posedge clock) begin
      if (state_ff == F_CLEAR) begin
         store_mem[clr_addr_ff] <= '0;
      end else if (state_ff == F_SCALE) begin
         store_mem[idx_ff] <= blend_ff;
      end
      store_rd_ff <= store_mem[idx_now];
   end

endmodule

`default_nettype wire

// ----- rtl/core/cvep_queue.sv -----
`default_nettype none

module cvep_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  cvep_pkg::cvep_job_type push_job,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output cvep_pkg::cvep_job_type pop_job
);
   import cvep_pkg::*;

   logic [QueueAw-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueueAw:0]   count_ff;
   cvep_job_type       entry_ff [QueueDepth];
   logic               do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != (QueueAw+1)'(QueueDepth));
      pop_valid  = (count_ff != '0);
      pop_job    = entry_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QueueAw'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QueueAw'(1);
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QueueAw+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QueueAw+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

// ----- rtl/core/cvep_back.sv -----
`default_nettype none

module cvep_back (
   input  logic                   clock,
   input  logic                   reset,
   input  cvep_pkg::cvep_cfg_type cfg,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  cvep_pkg::cvep_job_type pop_job,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cvep_pkg::cvep_rsp_type rsp_data
);
   import cvep_pkg::*;

   localparam int SW = EmitW + 2;

   cvep_back_state_type state_ff, state_in;

   logic [ColW-1:0]   c_ff;
   logic              row_end_ff, frame_last_ff, neg_ff;
   logic [EmitW-1:0]  emit_ff;
   logic [BurstW-1:0] n_ff;
   logic [1:0]        fk_ff;
   cvep_rgb_type      ch_ff, cur_ff, mix_ff, mix_in, last_ff, rb_rd_ff;
   logic              rsp_valid_ff;
   cvep_rsp_type      rsp_ff;

   logic [23:0]       rb_mem [MaxWidth];

   logic [2:0]        s_cl;
   logic              more_now, more_next, need_bleed, slot_free, fetch_done;
   logic [EmitW-1:0]  fx, emit_inc;
   logic signed [SW-1:0] fx_s, pos_s, neg_s, rs_s, bs_s, c_s;
   logic              r_ok, b_ok;
   logic [ColW-1:0]   rd_addr;
   logic [8:0]        inv_bw;
   logic [7:0]        avg_r, avg_g, avg_b;

   // emission window test: pending column e with n beats already out
   function automatic logic has_more(input logic [EmitW-1:0] e, input logic [BurstW-1:0] n,
                                     input logic [ColW-1:0] c, input logic row_end,
                                     input logic [2:0] s);
      logic [EmitW:0] lim;
      lim = {1'b0, e} + (EmitW+1)'(s) + (EmitW+1)'(1);
      if (n >= BurstW'(BurstMax)) return 1'b0;
      if (row_end) return ({1'b0, e} <= {2'b0, c}) ? 1'b1 : 1'b0;
      return (lim <= {2'b0, c}) ? 1'b1 : 1'b0;
   endfunction

   always_comb begin
      s_cl       = (cfg.chroma_offset > 3'(MaxShift)) ? 3'(MaxShift) : cfg.chroma_offset;
      emit_inc   = emit_ff + EmitW'(1);
      more_now   = has_more(emit_ff, n_ff, c_ff, row_end_ff, s_cl);
      more_next  = has_more(emit_inc, n_ff + BurstW'(1), c_ff, row_end_ff, s_cl);
      need_bleed = (cfg.bleed_weight >= 8'd3) && (emit_ff != '0)
                 && (emit_ff < {1'b0, c_ff});
      slot_free  = !rsp_valid_ff || !rsp_stall;
      fetch_done = (fk_ff == 2'd3);
   end

   // chroma source columns for the column being fetched
   always_comb begin
      fx    = (state_ff == B_FETCH_RT) ? emit_inc : emit_ff;
      fx_s  = signed'(SW'(fx));
      c_s   = signed'(SW'(c_ff));
      pos_s = fx_s + signed'(SW'(s_cl));
      neg_s = fx_s - signed'(SW'(s_cl));
      rs_s  = neg_ff ? pos_s : neg_s;
      bs_s  = neg_ff ? neg_s : pos_s;
      r_ok  = (s_cl != 3'd0) && (rs_s >= 0) && (rs_s <= c_s);
      b_ok  = (s_cl != 3'd0) && (bs_s >= 0) && (bs_s <= c_s);
      case (fk_ff)
         2'd0:    rd_addr = fx[ColW-1:0];
         2'd1:    rd_addr = rs_s[ColW-1:0];
         default: rd_addr = bs_s[ColW-1:0];
      endcase
   end

   // horizontal bleed toward the neighbor average
   always_comb begin
      inv_bw = 9'd256 - {1'b0, cfg.bleed_weight};
      avg_r  = 8'(({1'b0, last_ff.r} + {1'b0, ch_ff.r}) >> 1);
      avg_g  = 8'(({1'b0, last_ff.g} + {1'b0, ch_ff.g}) >> 1);
      avg_b  = 8'(({1'b0, last_ff.b} + {1'b0, ch_ff.b}) >> 1);
      if (need_bleed) begin
         mix_in.r = 8'((17'(cur_ff.r * inv_bw) + 17'(avg_r * cfg.bleed_weight)) >> 8);
         mix_in.g = 8'((17'(cur_ff.g * inv_bw) + 17'(avg_g * cfg.bleed_weight)) >> 8);
         mix_in.b = 8'((17'(cur_ff.b * inv_bw) + 17'(avg_b * cfg.bleed_weight)) >> 8);
      end else begin
         mix_in = ch_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) state_in = B_CHECK;
         end
         B_CHECK: state_in = more_now ? B_FETCH_CUR : B_IDLE;
         B_FETCH_CUR: begin
            if (fetch_done) state_in = need_bleed ? B_FETCH_RT : B_MIX;
         end
         B_FETCH_RT: begin
            if (fetch_done) state_in = B_MIX;
         end
         B_MIX: state_in = B_EMIT;
         B_EMIT: begin
            if (slot_free) state_in = B_CHECK;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready = (state_ff == B_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         emit_ff      <= '0;
         n_ff         <= '0;
         fk_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_IDLE && pop_valid) n_ff <= '0;
         if (state_ff == B_CHECK && !more_now && row_end_ff) emit_ff <= '0;
         if (state_ff == B_FETCH_CUR || state_ff == B_FETCH_RT) begin
            fk_ff <= fk_ff + 2'd1;
         end
         if (state_ff == B_EMIT && slot_free) begin
            emit_ff      <= emit_inc;
            n_ff         <= n_ff + BurstW'(1);
            last_ff      <= mix_ff;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && pop_valid) begin
         c_ff          <= pop_job.column;
         row_end_ff    <= pop_job.row_end;
         frame_last_ff <= pop_job.frame_last;
         neg_ff        <= pop_job.shift_neg;
      end
      if (state_ff == B_FETCH_CUR || state_ff == B_FETCH_RT) begin
         case (fk_ff)
            2'd1: ch_ff <= rb_rd_ff;
            2'd2: begin
               if (r_ok) ch_ff.r <= rb_rd_ff.r;
            end
            2'd3: begin
               if (b_ok) ch_ff.b <= rb_rd_ff.b;
            end
            default: begin
               if (state_ff == B_FETCH_RT) cur_ff <= ch_ff;
            end
         endcase
      end
      if (state_ff == B_MIX) mix_ff <= mix_in;
      if (state_ff == B_EMIT && slot_free) begin
         rsp_ff.out_red   <= mix_ff.r;
         rsp_ff.out_green <= mix_ff.g;
         rsp_ff.out_blue  <= mix_ff.b;
         rsp_ff.run_last  <= !more_next;
         rsp_ff.frame_end <= frame_last_ff && (emit_ff == {1'b0, c_ff});
      end
   end

   // row buffer: one write per popped pixel, one registered read per cycle
   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && pop_valid) rb_mem[pop_job.column] <= pop_job.pixel;
      rb_rd_ff <= rb_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/crt_video_effect_pipeline.sv -----
`default_nettype none

// CRT video effect pipeline. Pixels arrive in raster order on the req_ channel;
// each one is blended with the previous frame, darkened on even rows, and
// queued for the back end, which applies red/blue displacement and horizontal
// bleed and sends up to six processed pixels per input on the rsp_ channel.
// After reset the 131072-entry frame store is zeroed, one entry per cycle,
// and req_stall stays high until that is done. The front end then handles
// one pixel at a time (store read, blend, scale, hand-off); the back end
// fetches each emitted pixel, and its right neighbor when bleed mixes it in,
// with three reads through the single read port of the row buffer for each
// displaced pixel. A four-entry queue lets the front run ahead of the back.
module crt_video_effect_pipeline (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cvep_pkg::cvep_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cvep_pkg::cvep_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_index,
   input  logic [9:0]             csr_wdata
);
   import cvep_pkg::*;

   cvep_cfg_type cfg_ff;
   logic         q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
   cvep_job_type q_push_job, q_pop_job;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.persistence_weight <= 8'd77;
         cfg_ff.scanline_strength  <= 8'd0;
         cfg_ff.chroma_offset      <= 3'd0;
         cfg_ff.bleed_weight       <= 8'd0;
         cfg_ff.frame_width        <= 10'd512;
         cfg_ff.frame_height       <= 9'd256;
      end else if (csr_wr_en) begin
         case (cvep_csr_type'(csr_index))
            CSR_PERSISTENCE: cfg_ff.persistence_weight <= csr_wdata[7:0];
            CSR_SCANLINE:    cfg_ff.scanline_strength  <= csr_wdata[7:0];
            CSR_CHROMA:      cfg_ff.chroma_offset      <= csr_wdata[2:0];
            CSR_BLEED:       cfg_ff.bleed_weight       <= csr_wdata[7:0];
            CSR_WIDTH:       cfg_ff.frame_width        <= csr_wdata;
            CSR_HEIGHT:      cfg_ff.frame_height       <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   cvep_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_job   (q_push_job)
   );

   cvep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_job   (q_push_job),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_job    (q_pop_job)
   );

   cvep_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_job   (q_pop_job),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // the store clearing pass holds off input right after reset
   a_clear_after_reset: assert property (@(posedge clock) $past(reset) |-> req_stall)
      else $error("pixel accepted during frame store clearing");

   // a job handed to the queue is visible to the back end next cycle
   a_queue_keeps_job: assert property (@(posedge clock) disable iff (reset)
      (q_push_valid && q_push_ready) |=> q_pop_valid)
      else $error("queued job lost");

   // a frame-final beat always closes its run
   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_end) |-> rsp_data.run_last)
      else $error("frame end beat not marked as last");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/crt_video_effect_pipeline_tb.sv -----
`timescale 1ns / 100ps

module crt_video_effect_pipeline_tb;
   import cvep_pkg::*;

   localparam int WatchLimit = 400000;
   localparam int DrainWait  = 300;
   localparam int HoldCycles = 3000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   cvep_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   cvep_rsp_type rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [9:0]   csr_wdata = '0;

   crt_video_effect_pipeline i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow configuration and pipeline state
   logic [7:0]  sh_persist = 8'd77;
   logic [7:0]  sh_scan    = 8'd0;
   logic [2:0]  sh_chroma  = 3'd0;
   logic [7:0]  sh_bleed   = 8'd0;
   logic [9:0]  sh_width   = 10'd512;
   logic [8:0]  sh_height  = 9'd256;
   logic [23:0] frame_mem [StoreDepth];
   logic [23:0] row_mem [MaxWidth];
   logic [23:0] prev_bled = '0;
   int          col_cnt = 0;
   int          row_cnt = 0;
   int          next_emit = 0;

   cvep_rsp_type pixel_expect[$];
   int           fails = 0;
   int           idle_pct = 0;
   int           stall_pct = 0;
   bit           hold_req = 1'b0;
   int           hold_left = 0;
   int           quiet_cycles = 0;

   initial begin
      for (int i = 0; i < StoreDepth; i++) frame_mem[i] = '0;
      for (int i = 0; i < MaxWidth; i++) row_mem[i] = '0;
   end

   function automatic logic [23:0] row_get(int i);
      if (i < 0 || i >= MaxWidth) return '0;
      return row_mem[i];
   endfunction

   // red from x-sh and blue from x+sh, sources limited to 0..last
   function automatic logic [23:0] displaced_at(int x, int last, int sh);
      logic [23:0] v;
      logic [23:0] src;
      int rs;
      int bs;
      v = row_get(x);
      if (sh == 0) return v;
      rs = x - sh;
      bs = x + sh;
      if (rs >= 0 && rs <= last) begin
         src = row_get(rs);
         v[23:16] = src[23:16];
      end
      if (bs >= 0 && bs <= last) begin
         src = row_get(bs);
         v[7:0] = src[7:0];
      end
      return v;
   endfunction

   function automatic int mix8(int cur, int avg, int wt);
      return (cur * (256 - wt) + avg * wt) >> 8;
   endfunction

   // advance the shadow pipeline by one pixel; expected beats go to pixel_expect
   function automatic void process_pixel(input cvep_req_type px, output cvep_rsp_type tail);
      int w, h, s, c, hi, sh, n, x, idx;
      int r, g, b, p, a, bw, ar, ag, ab;
      logic [23:0] pv, val, rt;
      bit row_end, frame_last;
      cvep_rsp_type burst[$];
      cvep_rsp_type o;
      w = sh_width; h = sh_height; s = sh_chroma;
      p = sh_persist; a = sh_scan; bw = sh_bleed;
      r = px.pixel_red; g = px.pixel_green; b = px.pixel_blue;
      if (w < 3) w = 3;
      if (w > MaxWidth) w = MaxWidth;
      if (h < 1) h = 1;
      if (h > MaxHeight) h = MaxHeight;
      if (s > MaxShift) s = MaxShift;
      if (col_cnt >= MaxWidth) col_cnt = MaxWidth - 1;
      c = col_cnt;
      idx = (row_cnt * w + col_cnt) % StoreDepth;
      if (p >= 3) begin
         pv = frame_mem[idx];
         r = (pv[23:16] * p + r * (256 - p)) >> 8;
         g = (pv[15:8] * p + g * (256 - p)) >> 8;
         b = (pv[7:0] * p + b * (256 - p)) >> 8;
      end
      frame_mem[idx] = {r[7:0], g[7:0], b[7:0]};
      if (a > 0 && row_cnt % 2 == 0) begin
         r = r * (255 - a) / 255;
         g = g * (255 - a) / 255;
         b = b * (255 - a) / 255;
      end
      row_mem[c] = {r[7:0], g[7:0], b[7:0]};
      row_end = (col_cnt >= w - 1);
      frame_last = row_end && (row_cnt >= h - 1);
      hi = row_end ? c : c - s - 1;
      sh = (px.frame_number % 30 < 15) ? s : -s;
      n = 0;
      while (next_emit <= hi && n < BurstMax) begin
         x = next_emit;
         val = displaced_at(x, c, sh);
         if (bw >= 3 && x >= 1 && x < c) begin
            rt = displaced_at(x + 1, c, sh);
            ar = (prev_bled[23:16] + rt[23:16]) >> 1;
            ag = (prev_bled[15:8] + rt[15:8]) >> 1;
            ab = (prev_bled[7:0] + rt[7:0]) >> 1;
            r = mix8(val[23:16], ar, bw);
            g = mix8(val[15:8], ag, bw);
            b = mix8(val[7:0], ab, bw);
            val = {r[7:0], g[7:0], b[7:0]};
         end
         prev_bled = val;
         o.out_red = val[23:16];
         o.out_green = val[15:8];
         o.out_blue = val[7:0];
         o.run_last = 1'b0;
         o.frame_end = frame_last && (x == c);
         burst.push_back(o);
         n++;
         next_emit++;
      end
      tail = '0;
      if (n > 0) begin
         burst[n - 1].run_last = 1'b1;
         tail = burst[n - 1];
      end
      foreach (burst[i]) pixel_expect.push_back(burst[i]);
      if (row_end) begin
         col_cnt = 0;
         next_emit = 0;
         row_cnt++;
         if (row_cnt >= h) row_cnt = 0;
      end else begin
         col_cnt++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      cvep_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_expect.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_data);
            fails++;
         end else begin
            want = pixel_expect.pop_front();
            if (rsp_data.out_red !== want.out_red)
               $display("%0t: out_red exp %h got %h", $time, want.out_red, rsp_data.out_red);
            if (rsp_data.out_green !== want.out_green)
               $display("%0t: out_green exp %h got %h", $time, want.out_green,
                        rsp_data.out_green);
            if (rsp_data.out_blue !== want.out_blue)
               $display("%0t: out_blue exp %h got %h", $time, want.out_blue,
                        rsp_data.out_blue);
            if (rsp_data.run_last !== want.run_last)
               $display("%0t: run_last exp %b got %b", $time, want.run_last,
                        rsp_data.run_last);
            if (rsp_data.frame_end !== want.frame_end)
               $display("%0t: frame_end exp %b got %b", $time, want.frame_end,
                        rsp_data.frame_end);
            if (rsp_data !== want) fails++;
         end
      end
   end

   // watchdog on cycles with no beat accepted on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("crt_video_effect_pipeline verification failed");
         $finish;
      end
   end

   // receiver stall, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HoldCycles;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // all tasks start and end just after a falling edge
   task automatic send_beat(input cvep_req_type d, output cvep_rsp_type tail);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      process_pixel(d, tail);
      @(negedge clock);
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      while (pixel_expect.size() != 0) @(negedge clock);
      repeat (DrainWait) @(negedge clock);
   endtask

   task automatic write_reg(input cvep_csr_type idx, input logic [9:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_PERSISTENCE: sh_persist = val[7:0];
         CSR_SCANLINE:    sh_scan = val[7:0];
         CSR_CHROMA:      sh_chroma = val[2:0];
         CSR_BLEED:       sh_bleed = val[7:0];
         CSR_WIDTH:       sh_width = val;
         CSR_HEIGHT:      sh_height = val[8:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic cvep_req_type rand_pixel(logic [31:0] fnum);
      cvep_req_type d;
      d.pixel_red = 8'($urandom);
      d.pixel_green = 8'($urandom);
      d.pixel_blue = 8'($urandom);
      d.frame_number = fnum;
      return d;
   endfunction

   function automatic logic [7:0] rand_weight();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(2, 3));
         default: return 8'($urandom);
      endcase
   endfunction

   // directed table
   typedef struct {
      bit           is_reg;
      cvep_csr_type idx;
      logic [9:0]   val;
      cvep_req_type px;
      bit           chk;
      cvep_rsp_type want;
   } step_row_type;

   step_row_type dir_table[$];

   function automatic void add_reg(cvep_csr_type idx, logic [9:0] val);
      step_row_type row;
      row = '{1'b1, idx, val, '0, 1'b0, '0};
      dir_table.push_back(row);
   endfunction

   function automatic void add_pix(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [31:0] fnum, bit chk, cvep_rsp_type want);
      step_row_type row;
      row = '{1'b0, CSR_PERSISTENCE, '0, '{r, g, b, fnum}, chk, want};
      dir_table.push_back(row);
   endfunction

   initial begin
      cvep_rsp_type tail;
      cvep_req_type d;
      logic [31:0] fnum;
      int items;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset weights: 255 blends to 178 against an empty store
      add_reg(CSR_WIDTH, 10'd3);
      add_reg(CSR_HEIGHT, 10'd1);
      add_pix(8'hFF, 8'hFF, 8'hFF, 32'd0, 1'b0, '0);
      add_pix(8'h00, 8'h00, 8'h00, 32'd0, 1'b1, '{8'd178, 8'd178, 8'd178, 1'b1, 1'b0});
      add_pix(8'h00, 8'h00, 8'h00, 32'd0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1});
      // persistence off and full, full then slightest scanline darkening
      add_reg(CSR_PERSISTENCE, 10'd2);
      add_reg(CSR_SCANLINE, 10'd255);
      add_pix(8'hFF, 8'h00, 8'hFF, 32'd1, 1'b0, '0);
      add_pix(8'h00, 8'hFF, 8'h00, 32'd1, 1'b0, '0);
      add_pix(8'hFF, 8'hFF, 8'hFF, 32'd1, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1});
      add_reg(CSR_PERSISTENCE, 10'd255);
      add_reg(CSR_SCANLINE, 10'd1);
      add_reg(CSR_HEIGHT, 10'd2);
      for (int i = 0; i < 6; i++)
         add_pix(8'($urandom), 8'($urandom), 8'($urandom), 32'd2, 1'b0, '0);
      // widest shift, direction flips, strongest bleed, wider row
      add_reg(CSR_PERSISTENCE, 10'd0);
      add_reg(CSR_CHROMA, 10'd7);
      add_reg(CSR_BLEED, 10'd255);
      add_reg(CSR_WIDTH, 10'd6);
      add_pix(8'h10, 8'h20, 8'h30, 32'd14, 1'b0, '0);
      add_pix(8'hF0, 8'h00, 8'h0F, 32'd15, 1'b0, '0);
      add_pix(8'h80, 8'h7F, 8'h01, 32'd29, 1'b0, '0);
      add_pix(8'h01, 8'hFE, 8'h80, 32'd30, 1'b0, '0);
      add_pix(8'hAA, 8'h55, 8'hAA, 32'hFFFFFFFF, 1'b0, '0);
      add_pix(8'h55, 8'hAA, 8'h55, 32'hFFFFFFFF, 1'b0, '0);
      // width saturates high, then shrinks mid-row so the row ends early
      add_reg(CSR_BLEED, 10'd3);
      add_reg(CSR_WIDTH, 10'd1023);
      add_reg(CSR_HEIGHT, 10'd511);
      for (int i = 0; i < 5; i++)
         add_pix(8'($urandom), 8'($urandom), 8'($urandom), 32'd3, 1'b0, '0);
      add_reg(CSR_WIDTH, 10'd0);
      add_reg(CSR_HEIGHT, 10'd0);
      add_pix(8'h00, 8'hFF, 8'h00, 32'd4, 1'b0, '0);

      foreach (dir_table[i]) begin
         if (dir_table[i].is_reg) begin
            drain_wait();
            write_reg(dir_table[i].idx, dir_table[i].val);
         end else begin
            send_beat(dir_table[i].px, tail);
            if (dir_table[i].chk && tail !== dir_table[i].want) begin
               $display("%0t: directed row %0d exp %h got %h", $time, i,
                        dir_table[i].want, tail);
               fails++;
            end
         end
      end

      // random phases: no idling but one long receiver hold-off, sender idle, receiver stalling, both
      for (int ph = 0; ph < 4; ph++) begin
         drain_wait();
         idle_pct = (ph == 1) ? 80 : (ph == 3) ? 12 : 0;
         stall_pct = (ph == 2) ? 80 : (ph == 3) ? 12 : 0;
         write_reg(CSR_PERSISTENCE, {2'b0, rand_weight()});
         write_reg(CSR_SCANLINE, {2'b0, rand_weight()});
         write_reg(CSR_CHROMA, 10'($urandom_range(7)));
         write_reg(CSR_BLEED, {2'b0, rand_weight()});
         write_reg(CSR_WIDTH, ($urandom_range(9) == 0) ? 10'($urandom) :
                              10'($urandom_range(3, 9)));
         write_reg(CSR_HEIGHT, ($urandom_range(9) == 0) ? 10'($urandom_range(511)) :
                               10'($urandom_range(1, 3)));
         fnum = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
         items = 36;
         for (int k = 0; k < items; k++) begin
            if (ph == 0 && k == 8) hold_req = 1'b1;
            if (ph == 1 && k == 20) begin
               req_valid <= 1'b0;
               @(negedge clock);
               while (pixel_expect.size() != 0) @(negedge clock);
            end
            d = rand_pixel(fnum);
            send_beat(d, tail);
            // a frame mostly keeps one number, sometimes it jumps
            if (tail.frame_end)
               fnum = ($urandom_range(4) == 0) ? $urandom : fnum + 1;
            else if ($urandom_range(19) == 0)
               fnum = $urandom;
         end
      end

      drain_wait();
      if (fails == 0) begin
         $display("crt_video_effect_pipeline verification clean");
      end else begin
         $display("crt_video_effect_pipeline verification failed");
      end
      $finish;
   end

endmodule
